// ===== hdl/sree_pkg.sv =====
// shared types and widths for the stencil refinement error estimator
package sree_pkg;

    localparam int NUM_AXES   = 3;
    localparam int ROOT_BITS  = 17;
    localparam int DIFF_W     = 34;
    localparam int DEN_AXIS_W = 51;
    localparam int NSQ_W      = 68;
    localparam int DSQ_W      = 102;
    localparam int NUM_W      = 70;
    localparam int DEN_W      = 104;
    localparam int TGT_W      = NUM_W + 64;
    localparam int PRD_W      = 122;
    localparam int CAND_W     = 140;
    localparam int PADDR_W    = 3;

    localparam logic MODE_FIRST  = 1'b0;
    localparam logic MODE_SECOND = 1'b1;

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_EPS  = 1'b1;

    localparam logic       MODE_RESET = MODE_SECOND;
    localparam logic [15:0] EPS_RESET = 16'd655;

    typedef struct packed {
        logic signed [31:0] center_value;
        logic signed [31:0] x_plus;
        logic signed [31:0] x_minus;
        logic signed [31:0] y_plus;
        logic signed [31:0] y_minus;
        logic signed [31:0] z_plus;
        logic signed [31:0] z_minus;
        logic [2:0]         low_edge_mask;
        logic [2:0]         high_edge_mask;
    } t_in_beat;

    typedef struct packed {
        logic [16:0] error_norm;
        logic        zero_denominator;
    } t_out_beat;

endpackage

// ===== hdl/sree_if.sv =====
// valid/ready channel interfaces for stencil and result beats
interface sree_in_if;
    logic                valid;
    logic                ready;
    sree_pkg::t_in_beat  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sree_out_if;
    logic                valid;
    logic                ready;
    sree_pkg::t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/stencil_refinement_error_estimator.sv =====
// top level: pipelined second/first derivative refinement error norm
// One stencil beat is taken per cycle while the output is not stalled; its result
// passes five front stages (differences, denominators, partial products, squares
// and sums), then seventeen stages of a bit-per-stage square root of the ratio of
// the sums, the last of which drives the output. Every stage holds when a result waits
// unread at the output, so throughput is one beat per cycle while the sink
// keeps up. Registers: mode at byte 0 (0 first derivative, 1 second
// derivative), noise weight in unsigned Q0.16 at byte 4. Write them only
// while the block is idle.
module stencil_refinement_error_estimator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sree_in_if.sink                         i_in,
    sree_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sree_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int NA = sree_pkg::NUM_AXES;
    localparam int RB = sree_pkg::ROOT_BITS;

    // configuration
    logic        r_mode;
    logic [15:0] r_eps;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == sree_pkg::REG_EPS) ? {16'd0, r_eps} : {31'd0, r_mode};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= sree_pkg::MODE_RESET;
            r_eps  <= sree_pkg::EPS_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == sree_pkg::REG_EPS) begin
                r_eps <= pwdata[15:0];
            end else begin
                r_mode <= pwdata[0];
            end
        end
    end

    // global advance
    logic w_en;
    logic r_v1, r_v2, r_v3, r_v4;
    logic r_sv [0:RB];

    assign w_en       = !r_sv[RB] || o_out.ready;
    assign i_in.ready = w_en;

    // stage 1: differences, edge copies, magnitudes
    logic signed [31:0] w_p [NA];
    logic signed [31:0] w_m [NA];
    logic signed [32:0] w_dp [NA];
    logic signed [32:0] w_dm [NA];
    logic signed [33:0] w_nsum [NA];
    logic [31:0]        w_ap [NA];
    logic [31:0]        w_am [NA];
    logic [32:0]        w_adp [NA];
    logic [32:0]        w_adm [NA];
    logic [31:0]        w_ac;
    logic [sree_pkg::DIFF_W-1:0] n1_n [NA];
    logic [sree_pkg::DIFF_W-1:0] n1_base [NA];
    logic [sree_pkg::DIFF_W-1:0] n1_s [NA];

    logic [sree_pkg::DIFF_W-1:0] r1_n [NA];
    logic [sree_pkg::DIFF_W-1:0] r1_base [NA];
    logic [sree_pkg::DIFF_W-1:0] r1_s [NA];
    logic                        r1_mode;
    logic [15:0]                 r1_eps;

    always_comb begin
        w_p[0] = i_in.data.x_plus;  w_m[0] = i_in.data.x_minus;
        w_p[1] = i_in.data.y_plus;  w_m[1] = i_in.data.y_minus;
        w_p[2] = i_in.data.z_plus;  w_m[2] = i_in.data.z_minus;
        w_ac = i_in.data.center_value[31] ? 32'(-i_in.data.center_value)
                                          : 32'(i_in.data.center_value);
        for (int a = 0; a < NA; a++) begin
            w_dp[a] = {w_p[a][31], w_p[a]} - {i_in.data.center_value[31],
                                              i_in.data.center_value};
            w_dm[a] = {i_in.data.center_value[31], i_in.data.center_value}
                      - {w_m[a][31], w_m[a]};
            if (i_in.data.low_edge_mask[a]) begin
                w_dm[a] = w_dp[a];
            end
            if (i_in.data.high_edge_mask[a]) begin
                w_dp[a] = w_dm[a];
            end
            if (r_mode == sree_pkg::MODE_FIRST) begin
                w_nsum[a] = {w_dp[a][32], w_dp[a]} + {w_dm[a][32], w_dm[a]};
            end else begin
                w_nsum[a] = {w_dp[a][32], w_dp[a]} - {w_dm[a][32], w_dm[a]};
            end
            n1_n[a]  = w_nsum[a][33] ? 34'(-w_nsum[a]) : 34'(w_nsum[a]);
            w_ap[a]  = w_p[a][31] ? 32'(-w_p[a]) : 32'(w_p[a]);
            w_am[a]  = w_m[a][31] ? 32'(-w_m[a]) : 32'(w_m[a]);
            w_adp[a] = w_dp[a][32] ? 33'(-w_dp[a]) : 33'(w_dp[a]);
            w_adm[a] = w_dm[a][32] ? 33'(-w_dm[a]) : 33'(w_dm[a]);
            if (r_mode == sree_pkg::MODE_FIRST) begin
                n1_base[a] = 34'(w_ap[a]) + 34'(w_am[a]);
            end else begin
                n1_base[a] = 34'(w_adp[a]) + 34'(w_adm[a]);
            end
            n1_s[a] = {1'b0, w_ac, 1'b0} + 34'(w_ap[a]) + 34'(w_am[a]);
        end
    end

    // stage 2: per-axis denominator
    logic [sree_pkg::DEN_AXIS_W-1:0] r2_d [NA];
    logic [sree_pkg::DIFF_W-1:0]     r2_n [NA];

    // stage 3: partial products
    logic [33:0] r3_nhh [NA];
    logic [33:0] r3_nhl [NA];
    logic [33:0] r3_nll [NA];
    logic [49:0] r3_dhh [NA];
    logic [50:0] r3_dhl [NA];
    logic [51:0] r3_dll [NA];

    // stage 4: squares
    logic [sree_pkg::NSQ_W-1:0] r4_n2 [NA];
    logic [sree_pkg::DSQ_W-1:0] r4_d2 [NA];

    // stage 5 feeds the root pipeline at index 0
    logic [sree_pkg::NUM_W-1:0]  r_snum [0:RB];
    logic [sree_pkg::DEN_W-1:0]  r_sden [0:RB];
    logic [sree_pkg::TGT_W-1:0]  r_sp   [0:RB];
    logic [sree_pkg::PRD_W-1:0]  r_sq   [0:RB];
    logic [RB-1:0]               r_sr   [0:RB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_mode <= r_mode;
            r1_eps  <= r_eps;
            for (int a = 0; a < NA; a++) begin
                r1_n[a]    <= n1_n[a];
                r1_base[a] <= n1_base[a];
                r1_s[a]    <= n1_s[a];
                r2_n[a]    <= r1_n[a];
                r2_d[a]    <= {1'b0, r1_base[a], 16'd0}
                              + ((r1_mode == sree_pkg::MODE_SECOND)
                                 ? 51'(50'(r1_eps) * 50'(r1_s[a])) : 51'd0);
                r3_nhh[a]  <= 34'(r2_n[a][33:17]) * 34'(r2_n[a][33:17]);
                r3_nhl[a]  <= 34'(r2_n[a][33:17]) * 34'(r2_n[a][16:0]);
                r3_nll[a]  <= 34'(r2_n[a][16:0])  * 34'(r2_n[a][16:0]);
                r3_dhh[a]  <= 50'(r2_d[a][50:26]) * 50'(r2_d[a][50:26]);
                r3_dhl[a]  <= 51'(r2_d[a][50:26]) * 51'(r2_d[a][25:0]);
                r3_dll[a]  <= 52'(r2_d[a][25:0])  * 52'(r2_d[a][25:0]);
                r4_n2[a]   <= (68'(r3_nhh[a]) << 34) + (68'(r3_nhl[a]) << 18)
                              + 68'(r3_nll[a]);
                r4_d2[a]   <= (102'(r3_dhh[a]) << 52) + (102'(r3_dhl[a]) << 27)
                              + 102'(r3_dll[a]);
            end
            r_snum[0] <= 70'(r4_n2[0]) + 70'(r4_n2[1]) + 70'(r4_n2[2]);
            r_sden[0] <= 104'(r4_d2[0]) + 104'(r4_d2[1]) + 104'(r4_d2[2]);
            r_sp[0]   <= '0;
            r_sq[0]   <= '0;
            r_sr[0]   <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (w_en) begin
            r_sv[0] <= r_v4;
        end
    end

    // square root: one result bit per stage, msb first
    for (genvar k = 0; k < RB; k++) begin : g_root
        localparam int B = RB - 1 - k;
        logic [sree_pkg::CAND_W-1:0] w_cand;
        logic [sree_pkg::CAND_W-1:0] w_tgt;
        logic                        w_ok;

        assign w_cand = sree_pkg::CAND_W'(r_sp[k])
                        + (sree_pkg::CAND_W'(r_sq[k]) << (B + 1))
                        + (sree_pkg::CAND_W'(r_sden[k]) << (2 * B));
        assign w_tgt  = sree_pkg::CAND_W'({r_snum[k], 64'd0});
        assign w_ok   = (w_cand <= w_tgt);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else if (w_en) begin
                r_sv[k+1] <= r_sv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_snum[k+1] <= r_snum[k];
                r_sden[k+1] <= r_sden[k];
                r_sp[k+1]   <= w_ok ? sree_pkg::TGT_W'(w_cand) : r_sp[k];
                r_sq[k+1]   <= w_ok ? sree_pkg::PRD_W'(sree_pkg::CAND_W'(r_sq[k])
                                       + (sree_pkg::CAND_W'(r_sden[k]) << B))
                                    : r_sq[k];
                r_sr[k+1]   <= w_ok ? (r_sr[k] | (RB'(1) << B)) : r_sr[k];
            end
        end
    end

    logic w_zero;
    assign w_zero = (r_sden[RB] == '0);

    assign o_out.valid                 = r_sv[RB];
    assign o_out.data.zero_denominator = w_zero;
    assign o_out.data.error_norm       = w_zero ? '0 : r_sr[RB];

    // checks
    a_zero_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.zero_denominator) |-> (o_out.data.error_norm == '0))
        else $error("zero denominator with nonzero norm");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable({r_v1, r_v2, r_v3, r_v4}) && $stable(r_sv[0])))
        else $error("pipeline moved during stall");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_v1)
        else $error("accepted beat not captured");

endmodule
